FILE: rtl/core/lcdnib_pkg.sv
// ============================================================================
// lcdnib_pkg
// Shared types, codes and sequence tables for the character LCD nibble
// port driver: request codes, register indexes, controller commands and the
// per-write micro-operations.
// ============================================================================
package lcdnib_pkg;

    localparam int MAX_ROWS = 4;
    localparam int MAX_COLS = 80;

    // Request codes carried on the input channel's tuser.
    localparam logic [2:0] REQ_CHAR  = 3'd0;
    localparam logic [2:0] REQ_CMD   = 3'd1;
    localparam logic [2:0] REQ_CLEAR = 3'd2;
    localparam logic [2:0] REQ_GOTO  = 3'd3;
    localparam logic [2:0] REQ_INIT  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_LINE_COUNT  = 3'd0;
    localparam logic [2:0] REG_LINE_LENGTH = 3'd1;
    localparam logic [2:0] REG_LINE0_START = 3'd2;
    localparam logic [2:0] REG_LINE1_START = 3'd3;
    localparam logic [2:0] REG_LINE2_START = 3'd4;
    localparam logic [2:0] REG_LINE3_START = 3'd5;

    // Expander port bits.
    localparam logic [7:0] BIT_RS    = 8'h10;
    localparam logic [7:0] BIT_RW    = 8'h20;
    localparam logic [7:0] BIT_E     = 8'h40;
    localparam logic [7:0] HIGH_MASK = 8'b11110000;
    localparam logic [7:0] LOW_MASK  = 8'h0F;

    // Display command bytes.
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    localparam logic [2:0] INIT_LAST_IDX  = 3'd6;
    localparam logic [2:0] BYTE_LAST_STEP = 3'd6;
    localparam logic [3:0] PRE_LAST_STEP  = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_PRE,
        ST_BYTE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_DATA,
        JOB_RAW,
        JOB_CLEAR,
        JOB_GOTO_IN,
        JOB_GOTO_NEXT,
        JOB_INIT_PRE,
        JOB_INIT_CMD
    } job_t;

    typedef enum logic [3:0] {
        OP_ZERO,
        OP_CLR_RSRW,
        OP_RS,
        OP_NIB_HI,
        OP_NIB_LO,
        OP_NIB3,
        OP_NIB2,
        OP_E_HI,
        OP_E_LO
    } op_t;

    typedef enum logic [2:0] {
        W_0,
        W_1,
        W_40,
        W_50,
        W_64,
        W_4992,
        W_20000
    } wait_t;

    typedef struct packed {
        op_t   op;
        wait_t wsel;
    } micro_t;

    typedef struct packed {
        logic       latch;
        job_t       job;
        logic [2:0] idx;
        logic       emit;
        micro_t     micro;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       wrap;
        logic       newline;
        logic       out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]      line_count;
        logic [6:0]      line_length;
        logic [3:0][6:0] line_start;
    } cfg_t;

    function automatic logic [14:0] wait_value(input wait_t w);
        case (w)
            W_0:     wait_value = 15'd0;
            W_1:     wait_value = 15'd1;
            W_40:    wait_value = 15'd40;
            W_50:    wait_value = 15'd50;
            W_64:    wait_value = 15'd64;
            W_4992:  wait_value = 15'd4992;
            W_20000: wait_value = 15'd20000;
            default: wait_value = 15'd0;
        endcase
    endfunction

    // Seven writes that move one byte to the display.
    function automatic micro_t byte_micro(input logic [2:0] k);
        case (k)
            3'd0:    byte_micro = '{op: OP_RS,     wsel: W_1};
            3'd1:    byte_micro = '{op: OP_NIB_HI, wsel: W_0};
            3'd2:    byte_micro = '{op: OP_E_HI,   wsel: W_1};
            3'd3:    byte_micro = '{op: OP_E_LO,   wsel: W_1};
            3'd4:    byte_micro = '{op: OP_NIB_LO, wsel: W_0};
            3'd5:    byte_micro = '{op: OP_E_HI,   wsel: W_1};
            default: byte_micro = '{op: OP_E_LO,   wsel: W_40};
        endcase
    endfunction

    // Power-up prologue before the 4-bit commands.
    function automatic micro_t pre_micro(input logic [3:0] k);
        case (k)
            4'd0:    pre_micro = '{op: OP_ZERO,     wsel: W_20000};
            4'd1:    pre_micro = '{op: OP_CLR_RSRW, wsel: W_0};
            4'd2:    pre_micro = '{op: OP_NIB3,     wsel: W_0};
            4'd3:    pre_micro = '{op: OP_E_HI,     wsel: W_1};
            4'd4:    pre_micro = '{op: OP_E_LO,     wsel: W_4992};
            4'd5:    pre_micro = '{op: OP_E_HI,     wsel: W_1};
            4'd6:    pre_micro = '{op: OP_E_LO,     wsel: W_50};
            4'd7:    pre_micro = '{op: OP_E_HI,     wsel: W_1};
            4'd8:    pre_micro = '{op: OP_E_LO,     wsel: W_64};
            4'd9:    pre_micro = '{op: OP_NIB2,     wsel: W_0};
            4'd10:   pre_micro = '{op: OP_E_HI,     wsel: W_1};
            default: pre_micro = '{op: OP_E_LO,     wsel: W_64};
        endcase
    endfunction

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        case (idx)
            3'd1:    init_cmd = CMD_FUNC_SET;
            3'd2:    init_cmd = CMD_DISP_OFF;
            3'd3:    init_cmd = CMD_ENTRY_MODE;
            3'd4:    init_cmd = CMD_CLEAR;
            3'd5:    init_cmd = CMD_SET_DDRAM;
            default: init_cmd = 8'h00;
        endcase
    endfunction

endpackage

FILE: rtl/core/char_lcd_nibble_port_driver.sv
// ============================================================================
// char_lcd_nibble_port_driver
// Character LCD driver in 4-bit mode behind an 8-bit expander port. Turns
// character, command, clear, go-to and init requests into port writes with
// the wait that must follow each one.
//
//   Channel   Ports                         Transaction when
//   request   s_tvalid/s_tready/s_tdata/s_tuser   s_tvalid && s_tready
//   result    m_tvalid/m_tready/m_tdata/m_tlast   m_tvalid && m_tready
//   config    psel/penable/pwrite/paddr/pwdata    psel && penable && pwrite
//
// One port write leaves per cycle while m_tready is high. Each byte sent to
// the display costs a planning step plus seven writes; a character with a line
// wrap sends two bytes, and init sends the power-up prologue before its commands.
// A new request is taken once the last write of the previous one sits in the
// output register. Reset is synchronous on aresetn; m_tready low stalls the
// sequencer in place.
// ============================================================================
module char_lcd_nibble_port_driver
    import lcdnib_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // value[7:0], col[14:8], row[16:15], zero pad
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // port_byte[7:0], wait_us[22:8], zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [7:0]  out_port_byte;
    logic [14:0] out_wait_us;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_count    <= 3'd2;
            cfg_reg.line_length   <= 7'd16;
            cfg_reg.line_start[0] <= 7'd0;
            cfg_reg.line_start[1] <= 7'd64;
            cfg_reg.line_start[2] <= 7'd20;
            cfg_reg.line_start[3] <= 7'd84;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_LINE_COUNT:  cfg_reg.line_count    <= pwdata[2:0];
                REG_LINE_LENGTH: cfg_reg.line_length   <= pwdata[6:0];
                REG_LINE0_START: cfg_reg.line_start[0] <= pwdata[6:0];
                REG_LINE1_START: cfg_reg.line_start[1] <= pwdata[6:0];
                REG_LINE2_START: cfg_reg.line_start[2] <= pwdata[6:0];
                REG_LINE3_START: cfg_reg.line_start[3] <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LINE_COUNT:  prdata = {29'd0, cfg_reg.line_count};
            REG_LINE_LENGTH: prdata = {25'd0, cfg_reg.line_length};
            REG_LINE0_START: prdata = {25'd0, cfg_reg.line_start[0]};
            REG_LINE1_START: prdata = {25'd0, cfg_reg.line_start[1]};
            REG_LINE2_START: prdata = {25'd0, cfg_reg.line_start[2]};
            REG_LINE3_START: prdata = {25'd0, cfg_reg.line_start[3]};
            default:         prdata = 32'd0;
        endcase
    end

    lcdnib_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcdnib_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .stat          (stat),
        .in_req_type   (s_tuser),
        .in_value      (s_tdata[7:0]),
        .in_col        (s_tdata[14:8]),
        .in_row        (s_tdata[16:15]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_port_byte (out_port_byte),
        .out_wait_us   (out_wait_us),
        .out_last      (m_tlast)
    );

    assign m_tdata = {1'b0, out_wait_us, out_port_byte};

    // A request is never taken twice in a row: planning follows acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one is being planned");

    // An enable pulse is always held for exactly one microsecond.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[22:8] == 15'd1))
        else $error("E high write without a one microsecond wait");

    // The driver only writes to the display, so RW stays low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[5])
        else $error("RW bit set on a port write");

endmodule

FILE: rtl/core/lcdnib_ctrl.sv
// ============================================================================
// lcdnib_ctrl
// Controller: plans the byte jobs of a request and steps through the port
// writes of each job, one write per cycle while the output stage is free.
// ============================================================================
module lcdnib_ctrl
    import lcdnib_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [2:0]  jcnt_reg, jcnt_next;
    logic        last_job_reg, last_job_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= 4'd0;
            jcnt_reg     <= 3'd0;
            last_job_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            jcnt_reg     <= jcnt_next;
            last_job_reg <= last_job_next;
        end
    end

    // Next state and sequencing counters.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        jcnt_next     = jcnt_reg;
        last_job_next = last_job_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_PLAN;
                    jcnt_next  = 3'd0;
                end
            end
            ST_PLAN: begin
                step_next  = 4'd0;
                jcnt_next  = jcnt_reg + 3'd1;
                state_next = ST_BYTE;
                case (stat.req)
                    REQ_CHAR:  last_job_next = !(jcnt_reg == 3'd0 && stat.wrap);
                    REQ_CMD:   last_job_next = 1'b1;
                    REQ_CLEAR: last_job_next = 1'b1;
                    REQ_GOTO:  last_job_next = 1'b1;
                    REQ_INIT: begin
                        if (jcnt_reg == 3'd0) begin
                            state_next    = ST_PRE;
                            last_job_next = 1'b0;
                        end else begin
                            last_job_next = (jcnt_reg == INIT_LAST_IDX);
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PRE: begin
                if (stat.out_free) begin
                    if (step_reg == PRE_LAST_STEP) begin
                        state_next = ST_PLAN;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            ST_BYTE: begin
                if (stat.out_free) begin
                    if (step_reg[2:0] == BYTE_LAST_STEP) begin
                        state_next = last_job_reg ? ST_IDLE : ST_PLAN;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        in_ready  = 1'b0;
        cmd       = '0;
        cmd.job   = JOB_NONE;
        cmd.idx   = jcnt_reg;
        cmd.micro = byte_micro(step_reg[2:0]);
        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_PLAN: begin
                case (stat.req)
                    REQ_CHAR: begin
                        if (jcnt_reg == 3'd0 && stat.wrap) begin
                            cmd.job = JOB_GOTO_NEXT;
                        end else begin
                            cmd.job = stat.newline ? JOB_GOTO_NEXT : JOB_DATA;
                        end
                    end
                    REQ_CMD:   cmd.job = JOB_RAW;
                    REQ_CLEAR: cmd.job = JOB_CLEAR;
                    REQ_GOTO:  cmd.job = JOB_GOTO_IN;
                    REQ_INIT:  cmd.job = (jcnt_reg == 3'd0) ? JOB_INIT_PRE : JOB_INIT_CMD;
                    default:   cmd.job = JOB_NONE;
                endcase
            end
            ST_PRE: begin
                cmd.emit  = stat.out_free;
                cmd.micro = pre_micro(step_reg);
            end
            ST_BYTE: begin
                cmd.emit = stat.out_free;
                cmd.last = last_job_reg && (step_reg[2:0] == BYTE_LAST_STEP);
            end
            default: cmd.job = JOB_NONE;
        endcase
    end

endmodule

FILE: rtl/core/lcdnib_dp.sv
// ============================================================================
// lcdnib_dp
// Datapath: request registers, cursor, port shadow, byte and address
// computation, and the output register of the result channel.
// ============================================================================
module lcdnib_dp
    import lcdnib_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [2:0]  in_req_type,
    input  logic [7:0]  in_value,
    input  logic [6:0]  in_col,
    input  logic [1:0]  in_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_port_byte,
    output logic [14:0] out_wait_us,
    output logic        out_last
);

    logic [2:0]  req_reg;
    logic [7:0]  val_reg;
    logic [6:0]  col_reg;
    logic [1:0]  row_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic [7:0]  shadow_reg;
    logic [6:0]  cur_col_reg, cur_col_next;
    logic [1:0]  cur_row_reg, cur_row_next;
    logic        valid_reg;
    logic [7:0]  port_reg;
    logic [14:0] wait_reg;
    logic        last_reg;

    logic [2:0]  rows_used;
    logic [6:0]  cols_used;
    logic [6:0]  tgt_x, fix_x;
    logic [2:0]  tgt_y, fix_y;
    logic [7:0]  ddram_addr;
    logic [7:0]  port_val;

    assign rows_used = (cfg.line_count > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : cfg.line_count;
    assign cols_used = (cfg.line_length > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.line_length;

    assign stat.req      = req_reg;
    assign stat.wrap     = (cur_col_reg >= cols_used);
    assign stat.newline  = (val_reg == CHAR_NEWLINE);
    assign stat.out_free = !valid_reg || out_ready;

    // Go-to target with out-of-range column or row folded to 0.
    always_comb begin
        if (cmd.job == JOB_GOTO_IN) begin
            tgt_x = col_reg;
            tgt_y = {1'b0, row_reg};
        end else begin
            tgt_x = 7'd0;
            tgt_y = {1'b0, cur_row_reg} + 3'd1;
        end
        fix_x      = (tgt_x >= cols_used) ? 7'd0 : tgt_x;
        fix_y      = (tgt_y >= rows_used) ? 3'd0 : tgt_y;
        ddram_addr = CMD_SET_DDRAM + {1'b0, cfg.line_start[fix_y[1:0]]} + {1'b0, fix_x};
    end

    always_comb begin
        byte_next    = byte_reg;
        rs_next      = rs_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (cmd.job)
            JOB_DATA: begin
                byte_next    = val_reg;
                rs_next      = 1'b1;
                cur_col_next = cur_col_reg + 7'd1;
            end
            JOB_RAW: begin
                byte_next = val_reg;
                rs_next   = 1'b0;
            end
            JOB_CLEAR: begin
                byte_next    = CMD_CLEAR;
                rs_next      = 1'b0;
                cur_col_next = 7'd0;
                cur_row_next = 2'd0;
            end
            JOB_GOTO_IN, JOB_GOTO_NEXT: begin
                byte_next    = ddram_addr;
                rs_next      = 1'b0;
                cur_col_next = fix_x;
                cur_row_next = fix_y[1:0];
            end
            JOB_INIT_PRE: begin
                cur_col_next = 7'd0;
                cur_row_next = 2'd0;
            end
            JOB_INIT_CMD: begin
                byte_next = (cmd.idx == INIT_LAST_IDX) ? val_reg : init_cmd(cmd.idx);
                rs_next   = 1'b0;
            end
            default: begin
                byte_next = byte_reg;
            end
        endcase
    end

    // Every write but the all-zero one is derived from the shadow, so only the intended bits move.
    always_comb begin
        case (cmd.micro.op)
            OP_ZERO:     port_val = 8'h00;
            OP_CLR_RSRW: port_val = shadow_reg & ~(BIT_RS | BIT_RW);
            OP_RS:       port_val = rs_reg ? ((shadow_reg & ~BIT_RW) | BIT_RS)
                                           : (shadow_reg & ~(BIT_RW | BIT_RS));
            OP_NIB_HI:   port_val = (shadow_reg & HIGH_MASK) | {4'h0, byte_reg[7:4]};
            OP_NIB_LO:   port_val = (shadow_reg & HIGH_MASK) | (byte_reg & LOW_MASK);
            OP_NIB3:     port_val = (shadow_reg & HIGH_MASK) | 8'h03;
            OP_NIB2:     port_val = (shadow_reg & HIGH_MASK) | 8'h02;
            OP_E_HI:     port_val = shadow_reg | BIT_E;
            OP_E_LO:     port_val = shadow_reg & ~BIT_E;
            default:     port_val = shadow_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shadow_reg  <= 8'h00;
            cur_col_reg <= 7'd0;
            cur_row_reg <= 2'd0;
            valid_reg   <= 1'b0;
            req_reg     <= REQ_CHAR;
        end else begin
            if (cmd.latch) begin
                req_reg <= in_req_type;
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cmd.emit) begin
                shadow_reg <= port_val;
                valid_reg  <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            val_reg <= in_value;
            col_reg <= in_col;
            row_reg <= in_row;
        end
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
        if (cmd.emit) begin
            port_reg <= port_val;
            wait_reg <= wait_value(cmd.micro.wsel);
            last_reg <= cmd.last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_port_byte = port_reg;
    assign out_wait_us   = wait_reg;
    assign out_last      = last_reg;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: character LCD nibble port driver
// Sends character, command, clear, go-to and init requests on the input
// stream and checks every expander write that comes back against a predictor
// of the port shadow, the cursor and the line registers. A short directed
// table covers the field extremes and the wrap and range repair cases. It is
// followed by randomized phases, each under its own register setting, most with
// random backpressure on the results and some also with idle gaps on requests.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdnib_pkg::*;

    // Request codes that the block has to ignore.
    localparam logic [2:0] REQ_RSVD_5 = 3'd5;
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    localparam int PHASES        = 6;
    localparam int REQS_PER_PH   = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SHOWN     = 10;
    localparam int CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        logic [7:0]  port;
        logic [14:0] wait_us;
        logic        is_last;
    } lcd_write_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // code is a request code for ROW_REQ rows and a register index for ROW_CFG.
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  code;
        logic [7:0]  value;
        logic [6:0]  col;
        logic [1:0]  row;
        logic        typed;
        logic [7:0]  exp_port;
        logic [14:0] exp_wait;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // value[7:0], col[14:8], row[16:15], zero pad
    logic [2:0]  s_tuser  = '0;  // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // port_byte[7:0], wait_us[22:8], zero pad
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    logic [7:0]  shadow;
    logic [6:0]  cur_col;
    logic [1:0]  cur_row;
    logic [2:0]  lines_cfg;
    logic [6:0]  len_cfg;
    logic [6:0]  base_cfg [4];

    lcd_write_t  batch [$];
    lcd_write_t  port_q [$];

    int          errors      = 0;
    int          results_seen = 0;
    int unsigned cycle_cnt   = 0;
    int          stall_left  = 0;
    bit          sink_stalls = 1'b1;
    bit          src_gaps    = 1'b1;

    dir_row_t dir_tab [0:32] = '{
        '{ROW_REQ, REQ_INIT,        8'h0C, 7'd0,   2'd0, 1'b1, 8'h0C, 15'd40},
        '{ROW_REQ, REQ_CMD,         8'hFF, 7'd0,   2'd0, 1'b1, 8'h0F, 15'd40},
        '{ROW_REQ, REQ_CMD,         8'h00, 7'd0,   2'd0, 1'b1, 8'h00, 15'd40},
        '{ROW_REQ, REQ_CHAR,        8'hA5, 7'd0,   2'd0, 1'b1, 8'h15, 15'd40},
        '{ROW_REQ, REQ_CHAR,        8'h00, 7'd127, 2'd3, 1'b1, 8'h10, 15'd40},
        '{ROW_REQ, REQ_CHAR,        8'hFF, 7'd0,   2'd0, 1'b1, 8'h1F, 15'd40},
        '{ROW_REQ, REQ_CHAR,        8'h0A, 7'd0,   2'd0, 1'b1, 8'h00, 15'd40},
        '{ROW_REQ, REQ_CLEAR,       8'h00, 7'd0,   2'd0, 1'b1, 8'h01, 15'd40},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd15,  2'd1, 1'b1, 8'h0F, 15'd40},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd16,  2'd1, 1'b1, 8'h00, 15'd40},
        '{ROW_REQ, REQ_GOTO,        8'hFF, 7'd127, 2'd3, 1'b1, 8'h00, 15'd40},
        '{ROW_REQ, REQ_RSVD_5,      8'hFF, 7'd127, 2'd3, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_RSVD_6,      8'h00, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_RSVD_7,      8'h55, 7'd42,  2'd2, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd15,  2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h41, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h42, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE_COUNT,  8'd0,  7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE_LENGTH, 8'd0,  7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE0_START, 8'd127, 7'd0,  2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE1_START, 8'd0,  7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE2_START, 8'd127, 7'd0,  2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE3_START, 8'd99, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h33, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd0,   2'd2, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE_COUNT,  8'd7,  7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE_LENGTH, 8'd127, 7'd0,  2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd79,  2'd3, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h7E, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h7F, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_GOTO,        8'h00, 7'd40,  2'd1, 1'b0, 8'h00, 15'd0},
        '{ROW_CFG, REG_LINE_LENGTH, 8'd8,  7'd0,   2'd0, 1'b0, 8'h00, 15'd0},
        '{ROW_REQ, REQ_CHAR,        8'h21, 7'd0,   2'd0, 1'b0, 8'h00, 15'd0}
    };

    char_lcd_nibble_port_driver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic int rows_in_use();
        return (int'(lines_cfg) > MAX_ROWS) ? MAX_ROWS : int'(lines_cfg);
    endfunction

    function automatic int cols_in_use();
        return (int'(len_cfg) > MAX_COLS) ? MAX_COLS : int'(len_cfg);
    endfunction

    task automatic put_write(input logic [7:0] b, input logic [14:0] w);
        shadow = b;
        batch.push_back('{port: b, wait_us: w, is_last: 1'b0});
    endtask

    task automatic put_nibble(input logic [3:0] nib, input logic [14:0] w);
        put_write((shadow & HIGH_MASK) | ({4'd0, nib} & LOW_MASK), w);
    endtask

    task automatic strobe_e(input logic [14:0] w_after);
        put_write(shadow | BIT_E, 15'd1);
        put_write(shadow & ~BIT_E, w_after);
    endtask

    task automatic send_lcd_byte(input bit rs, input logic [7:0] b);
        logic [7:0] p;
        p = shadow & ~BIT_RW;
        p = rs ? (p | BIT_RS) : (p & ~BIT_RS);
        put_write(p, 15'd1);
        put_nibble(b[7:4], 15'd0);
        strobe_e(15'd1);
        put_nibble(b[3:0], 15'd0);
        strobe_e(15'd40);
    endtask

    // Out-of-range rows and columns fall back to zero before the address is built.
    task automatic move_cursor(input int x, input int y);
        logic [7:0] addr;
        if (y >= rows_in_use()) y = 0;
        if (x >= cols_in_use()) x = 0;
        cur_col = x[6:0];
        cur_row = y[1:0];
        addr = CMD_SET_DDRAM + {1'b0, base_cfg[y[1:0]]} + x[7:0];
        send_lcd_byte(1'b0, addr);
    endtask

    task automatic plan_writes(input logic [2:0] req, input logic [7:0] val,
                               input logic [6:0] col, input logic [1:0] row);
        batch.delete();
        case (req)
            REQ_CHAR: begin
                if (int'(cur_col) >= cols_in_use()) move_cursor(0, int'(cur_row) + 1);
                if (val != CHAR_NEWLINE) begin
                    send_lcd_byte(1'b1, val);
                    cur_col = cur_col + 7'd1;
                end else begin
                    move_cursor(0, int'(cur_row) + 1);
                end
            end
            REQ_CMD: send_lcd_byte(1'b0, val);
            REQ_CLEAR: begin
                send_lcd_byte(1'b0, CMD_CLEAR);
                cur_col = '0;
                cur_row = '0;
            end
            REQ_GOTO: move_cursor(int'(col), int'(row));
            REQ_INIT: begin
                put_write(8'h00, 15'd20000);
                put_write(shadow & ~(BIT_RS | BIT_RW), 15'd0);
                put_nibble(4'h3, 15'd0);
                strobe_e(15'd4992);
                strobe_e(15'd50);
                strobe_e(15'd64);
                put_nibble(4'h2, 15'd0);
                strobe_e(15'd64);
                send_lcd_byte(1'b0, CMD_FUNC_SET);
                send_lcd_byte(1'b0, CMD_DISP_OFF);
                send_lcd_byte(1'b0, CMD_ENTRY_MODE);
                send_lcd_byte(1'b0, CMD_CLEAR);
                send_lcd_byte(1'b0, CMD_SET_DDRAM);
                send_lcd_byte(1'b0, val);
                cur_col = '0;
                cur_row = '0;
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].is_last = 1'b1;
    endtask

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int next_src_gap();
        if (src_gaps && $urandom_range(0, 2) == 0) return pick_gap();
        return 0;
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [7:0] val,
                                input logic [6:0] col, input logic [1:0] row,
                                input bit typed, input logic [7:0] exp_port,
                                input logic [14:0] exp_wait, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, row, col, val};
        do @(posedge aclk); while (!s_tready);
        plan_writes(req, val, col, row);
        if (typed && batch.size() > 0) begin
            batch[batch.size() - 1].port    = exp_port;
            batch[batch.size() - 1].wait_us = exp_wait;
        end
        foreach (batch[i]) port_q.push_back(batch[i]);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until the block has nothing left to emit.
    task automatic drain_results();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (port_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_LINE_COUNT:  lines_cfg   = data[2:0];
            REG_LINE_LENGTH: len_cfg     = data[6:0];
            REG_LINE0_START: base_cfg[0] = data[6:0];
            REG_LINE1_START: base_cfg[1] = data[6:0];
            REG_LINE2_START: base_cfg[2] = data[6:0];
            REG_LINE3_START: base_cfg[3] = data[6:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch_results
        lcd_write_t got;
        lcd_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{port: m_tdata[7:0], wait_us: m_tdata[22:8], is_last: m_tlast};
            if (port_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("tb: result %0d with nothing expected: port %h wait %0d last %b",
                             results_seen, got.port, got.wait_us, got.is_last);
            end else begin
                want = port_q.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("tb: result %0d mismatch: expected port %h wait %0d last %b,",
                                 results_seen, want.port, want.wait_us, want.is_last,
                                 " got port %h wait %0d last %b",
                                 got.port, got.wait_us, got.is_last);
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        logic [2:0] req;
        logic [7:0] val;
        logic [6:0] col;
        logic [1:0] row;
        logic [2:0] pick_lines;
        logic [6:0] pick_len;
        logic [6:0] pick_base [4];
        int         sent;
        int         r;

        shadow      = '0;
        cur_col     = '0;
        cur_row     = '0;
        lines_cfg   = 3'd2;
        len_cfg     = 7'd16;
        base_cfg[0] = 7'd0;
        base_cfg[1] = 7'd64;
        base_cfg[2] = 7'd20;
        base_cfg[3] = 7'd84;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                drain_results();
                apb_write(dir_tab[i].code, {24'd0, dir_tab[i].value});
            end else begin
                send_request(dir_tab[i].code, dir_tab[i].value, dir_tab[i].col,
                             dir_tab[i].row, dir_tab[i].typed, dir_tab[i].exp_port,
                             dir_tab[i].exp_wait, next_src_gap());
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            if (ph == 0) begin
                pick_lines = 3'd4;
                pick_len   = 7'd20;
                pick_base  = '{7'd0, 7'd64, 7'd20, 7'd84};
            end else if (ph == PHASES - 1) begin
                pick_lines = 3'd2;
                pick_len   = 7'd16;
                pick_base  = '{7'd0, 7'd64, 7'd20, 7'd84};
            end else begin
                pick_lines = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 5))
                    0: pick_len = 7'd1;
                    1: pick_len = 7'd80;
                    2: pick_len = 7'd127;
                    3: pick_len = 7'($urandom_range(4, 24));
                    default: pick_len = 7'($urandom_range(1, 127));
                endcase
                for (int k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 5))
                        0: pick_base[k] = 7'd0;
                        1: pick_base[k] = 7'd127;
                        default: pick_base[k] = 7'($urandom_range(0, 127));
                    endcase
                end
            end
            apb_write(REG_LINE_COUNT, {29'd0, pick_lines});
            apb_write(REG_LINE_LENGTH, {25'd0, pick_len});
            for (int k = 0; k < 4; k++)
                apb_write(REG_LINE0_START + 3'(k), {25'd0, pick_base[k]});

            // One phase in three runs with no idling on either side.
            src_gaps    = (ph % 3 == 1);
            sink_stalls = (ph % 3 != 0);

            sent = 0;
            while (sent < REQS_PER_PH) begin
                val = 8'($urandom_range(0, 255));
                col = 7'($urandom_range(0, 127));
                row = 2'($urandom_range(0, 3));
                r   = $urandom_range(0, 99);
                if (r < 50) begin
                    req = REQ_CHAR;
                    if ($urandom_range(0, 9) == 0) val = CHAR_NEWLINE;
                end else if (r < 60) begin
                    req = REQ_CMD;
                end else if (r < 65) begin
                    req = REQ_CLEAR;
                end else if (r < 80) begin
                    req = REQ_GOTO;
                    if ($urandom_range(0, 3) != 0)
                        col = 7'($urandom_range(0, int'(len_cfg)));
                end else if (r < 85) begin
                    req = REQ_INIT;
                end else if (r < 90) begin
                    req = 3'($urandom_range(int'(REQ_RSVD_5), int'(REQ_RSVD_7)));
                end else begin
                    req = REQ_CHAR;
                end
                send_request(req, val, col, row, 1'b0, 8'h00, 15'd0, next_src_gap());
                if (req <= REQ_INIT) sent++;
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (port_q.size() != 0) begin
            $display("tb: %0d expected writes never arrived", port_q.size());
            errors += port_q.size();
        end
        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: char_lcd_nibble_port_driver.f
rtl/core/lcdnib_pkg.sv
rtl/core/lcdnib_ctrl.sv
rtl/core/lcdnib_dp.sv
rtl/core/char_lcd_nibble_port_driver.sv
test/tb.sv
